/* design/dpfa_pkg.sv */
// Shared types, field widths and status codes of the frame allocator.
`timescale 1ns / 1ps
`default_nettype none
package dpfa_pkg;

  localparam int FRAME_COUNT_DEF = 1024;
  localparam int PAGE_BYTES_DEF  = 4096;

  localparam int HASH_W   = 32;
  localparam int ADDR_W   = 22;
  localparam int COUNT_W  = 16;
  localparam int STATUS_W = 3;
  localparam int FLAG_W   = 2;
  localparam int START_W  = 11;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_COLD  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_FOLDED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NEW       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_COLD      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_ADDR  = 3'd4;

  localparam logic [FLAG_W-1:0]  FLAG_ACTIVE = 2'b01;
  localparam logic [FLAG_W-1:0]  FLAG_COLD   = 2'b10;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 16'hFFFF;

  typedef struct packed {
    logic [FLAG_W-1:0]  flags;
    logic [COUNT_W-1:0] count;
    logic [HASH_W-1:0]  hash;
  } entry_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   frame_address;
    logic [COUNT_W-1:0]  ref_count;
  } res_t;

endpackage
`default_nettype wire

/* design/dpfa_table.sv */
// Frame table memory: one write port, one read port with registered data.
`timescale 1ns / 1ps
`default_nettype none
module dpfa_table
  import dpfa_pkg::*;
#(
  parameter int DEPTH = FRAME_COUNT_DEF,
  parameter int AW    = $clog2(FRAME_COUNT_DEF)
) (
  input  wire logic          clk_i,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output entry_t             rd_data_o,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  entry_t             wr_data_i
);

  entry_t mem [DEPTH];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

/* design/dpfa_ctrl.sv */
// Sequencer: table clear, hash scan with a shared compare, allocate and mark-cold.
`timescale 1ns / 1ps
`default_nettype none
module dpfa_ctrl
  import dpfa_pkg::*;
#(
  parameter int FRAME_COUNT = FRAME_COUNT_DEF,
  parameter int PAGE_BYTES  = PAGE_BYTES_DEF,
  parameter int IW          = $clog2(FRAME_COUNT_DEF)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [START_W-1:0] start_frame_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               in_opcode_i,
  input  wire logic [HASH_W-1:0]  in_hash_i,
  input  wire logic [ADDR_W-1:0]  in_addr_i,
  output logic                    res_valid_o,
  input  wire logic               res_ready_i,
  output res_t                    res_o,
  output logic                    rd_en_o,
  output logic [IW-1:0]           rd_addr_o,
  input  entry_t                  rd_data_i,
  output logic                    wr_en_o,
  output logic [IW-1:0]           wr_addr_o,
  output entry_t                  wr_data_o
);

  localparam int PS = $clog2(PAGE_BYTES);
  localparam int OW = $clog2(FRAME_COUNT + 1);
  localparam logic [31:0] FC32 = 32'(FRAME_COUNT);
  localparam logic [IW-1:0] LAST = IW'(FRAME_COUNT - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_ALLOC = 3'd3;
  localparam logic [2:0] S_COLD  = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [HASH_W-1:0] hash_q, hash_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic [IW-1:0]     scan_q, scan_d;
  logic              issue_q, issue_d;
  logic              chk_vld_q, chk_vld_d;
  logic [IW-1:0]     chk_idx_q, chk_idx_d;
  logic [OW-1:0]     offset_q, offset_d;
  res_t              res_q, res_d;

  logic [31:0]       frame_num;
  logic [31:0]       cand;
  logic              match;
  logic [COUNT_W-1:0] count_inc;

  function automatic logic [ADDR_W-1:0] to_addr(input logic [IW-1:0] idx);
    logic [IW+PS-1:0] wide;
    wide = (IW + PS)'(idx) << PS;
    return ADDR_W'(wide);
  endfunction

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_RESP);
  assign res_o       = res_q;

  assign frame_num = 32'(in_addr_i >> PS);
  assign cand      = 32'(start_frame_i) + 32'(offset_q);
  assign match     = chk_vld_q && (rd_data_i.hash == hash_q) && (rd_data_i.count != '0);
  assign count_inc = (rd_data_i.count == COUNT_MAX) ? COUNT_MAX : rd_data_i.count + 1'b1;

  always_comb begin
    state_d   = state_q;
    hash_d    = hash_q;
    idx_d     = idx_q;
    scan_d    = scan_q;
    issue_d   = issue_q;
    chk_vld_d = 1'b0;
    chk_idx_d = chk_idx_q;
    offset_d  = offset_q;
    res_d     = res_q;
    rd_en_o   = 1'b0;
    rd_addr_o = scan_q;
    wr_en_o   = 1'b0;
    wr_addr_o = idx_q;
    wr_data_o = '0;

    unique case (state_q)
      S_CLEAR: begin
        wr_en_o   = 1'b1;
        wr_addr_o = idx_q;
        if (idx_q == LAST) begin
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          hash_d = in_hash_i;
          if (in_opcode_i == OP_COLD) begin
            if (frame_num >= FC32) begin
              res_d   = '{status: ST_BAD_ADDR, frame_address: '0, ref_count: '0};
              state_d = S_RESP;
            end else begin
              rd_en_o   = 1'b1;
              rd_addr_o = IW'(frame_num);
              idx_d     = IW'(frame_num);
              state_d   = S_COLD;
            end
          end else if (in_hash_i != '0) begin
            scan_d  = '0;
            issue_d = 1'b1;
            state_d = S_SCAN;
          end else begin
            state_d = S_ALLOC;
          end
        end
      end
      S_SCAN: begin
        rd_en_o   = issue_q;
        rd_addr_o = scan_q;
        chk_vld_d = issue_q;
        chk_idx_d = scan_q;
        if (issue_q) begin
          if (scan_q == LAST) begin
            issue_d = 1'b0;
          end else begin
            scan_d = scan_q + 1'b1;
          end
        end
        if (match) begin
          wr_en_o   = 1'b1;
          wr_addr_o = chk_idx_q;
          wr_data_o = '{flags: rd_data_i.flags, count: count_inc, hash: rd_data_i.hash};
          res_d     = '{status: ST_FOLDED, frame_address: to_addr(chk_idx_q),
                        ref_count: count_inc};
          issue_d   = 1'b0;
          chk_vld_d = 1'b0;
          state_d   = S_RESP;
        end else if (chk_vld_q && (chk_idx_q == LAST)) begin
          chk_vld_d = 1'b0;
          state_d   = S_ALLOC;
        end
      end
      S_ALLOC: begin
        if (cand >= FC32) begin
          res_d = '{status: ST_EXHAUSTED, frame_address: '0, ref_count: '0};
        end else begin
          wr_en_o   = 1'b1;
          wr_addr_o = cand[IW-1:0];
          wr_data_o = '{flags: FLAG_ACTIVE, count: COUNT_W'(1), hash: hash_q};
          offset_d  = offset_q + 1'b1;
          res_d     = '{status: ST_NEW, frame_address: to_addr(cand[IW-1:0]),
                        ref_count: COUNT_W'(1)};
        end
        state_d = S_RESP;
      end
      S_COLD: begin
        wr_en_o   = 1'b1;
        wr_addr_o = idx_q;
        wr_data_o = '{flags: rd_data_i.flags | FLAG_COLD, count: rd_data_i.count,
                      hash: rd_data_i.hash};
        res_d     = '{status: ST_COLD, frame_address: to_addr(idx_q),
                      ref_count: rd_data_i.count};
        state_d   = S_RESP;
      end
      S_RESP: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      idx_q     <= '0;
      issue_q   <= 1'b0;
      chk_vld_q <= 1'b0;
      offset_q  <= '0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      issue_q   <= issue_d;
      chk_vld_q <= chk_vld_d;
      offset_q  <= offset_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hash_q    <= hash_d;
    scan_q    <= scan_d;
    chk_idx_q <= chk_idx_d;
    res_q     <= res_d;
  end

endmodule
`default_nettype wire

/* design/dedup_page_frame_allocator.sv */
// Top level: stream ports, configuration port, output register, sequencer and table.
// After reset the table is cleared one entry a cycle, from entry 0 to the last, with tready low.
// Allocate with a nonzero hash: one table read a cycle from entry 0 up to the last entry;
// the scan ends early at the first match.
// One item at a time; the next item is taken while a result waits in the output register.
`timescale 1ns / 1ps
`default_nettype none
module dedup_page_frame_allocator
  import dpfa_pkg::*;
#(
  parameter int FRAME_COUNT = FRAME_COUNT_DEF,
  parameter int PAGE_BYTES  = PAGE_BYTES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,   // content_hash[31:0], byte_address[53:32]
  input  wire logic [0:0]  s_axis_tuser,   // opcode[0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // frame_address[21:0], ref_count[37:22]
  output logic [2:0]       m_axis_tuser,   // status[2:0]
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int IW = $clog2(FRAME_COUNT);

  logic [START_W-1:0] start_q;
  logic               out_valid_q;
  res_t               out_q;
  res_t               res;
  logic               res_valid;
  logic               res_ready;
  logic               rd_en;
  logic [IW-1:0]      rd_addr;
  entry_t             rd_data;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  entry_t             wr_data;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? 32'(start_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      start_q <= pwdata[START_W-1:0];
    end
  end

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.ref_count, out_q.frame_address};
  assign m_axis_tuser  = out_q.status;

  dpfa_ctrl #(
    .FRAME_COUNT(FRAME_COUNT),
    .PAGE_BYTES (PAGE_BYTES),
    .IW         (IW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_frame_i(start_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_opcode_i  (s_axis_tuser[0]),
    .in_hash_i    (s_axis_tdata[31:0]),
    .in_addr_i    (s_axis_tdata[53:32]),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data)
  );

  dpfa_table #(
    .DEPTH(FRAME_COUNT),
    .AW   (IW)
  ) u_table (
    .clk_i    (clk_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

endmodule
`default_nettype wire
